// File: src/cdl_pkg.sv
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared types and constants of the credential deny-list checker.
// ----------------------------------------------------------------------------
package cdl_pkg;

  localparam int ID_W      = 32;
  localparam int ACT_W     = 3;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int LANES     = 8;
  localparam int LANE_BITS = 3;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_MAX_GROUPS  = 32;

  localparam logic [ID_W-1:0] MIN_ID_RST = 32'd1000;

  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_USER  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD_GROUP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_USER      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRIMARY   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SUPP      = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NONE         = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MALFORMED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_USER_RES     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PRIM_RES     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUPP_RES     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FORBID_USER  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FORBID_GROUP = 3'd6;

  localparam logic [POS_W-1:0] POS_EXPECT_USER = 7'd0;
  localparam logic [POS_W-1:0] POS_EXPECT_PRIM = 7'd1;
  localparam logic [POS_W-1:0] POS_GROUPS      = 7'd2;
  localparam logic [POS_W-1:0] POS_SAT         = 7'd127;

  typedef logic [LANES-1:0][ID_W-1:0] cdl_row_t;

  typedef struct packed {
    logic start;
    logic insert;
    logic clear;
  } cdl_tbl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cdl_tbl_rsp_t;

endpackage

// File: src/credential_denylist_checker.sv
// ----------------------------------------------------------------------------
// credential_denylist_checker
// Fills user and group deny sets and checks streamed credential sets against
// them and a reserved-id floor; reports allow or deny on a set's last word.
// ----------------------------------------------------------------------------
// Steps: each word is taken in IDLE and handled in DECIDE; a lookup or insert
//   adds SCAN, which reads one RAM row of eight ids per cycle up to the fill
//   count or a hit. The last word of a set then also passes through RESULT.
// Throughput: one input word at a time; the next is taken once this one ends.
//   A stalled result word holds off the input.
// Reset: control, counts and min_id (1000) reset; set RAMs are not cleared.
module credential_denylist_checker #(
  parameter int TABLE_DEPTH = cdl_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_GROUPS  = cdl_pkg::DEF_MAX_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cdl_pkg::ID_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cdl_pkg::ACT_W-1:0]     in_action,
  input  logic [cdl_pkg::ID_W-1:0]      in_id_value,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_allowed,
  output logic [cdl_pkg::KIND_W-1:0]    out_violation_kind,
  output logic [cdl_pkg::ID_W-1:0]      out_offending_id
);
  import cdl_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              last_r, last_nxt;
  logic [KIND_W-1:0] hit_kind_r, hit_kind_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [KIND_W-1:0] pkind_r, pkind_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [ID_W-1:0]   min_id_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_allowed_r, out_allowed_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;

  cdl_tbl_req_t usr_req, grp_req;
  cdl_tbl_rsp_t usr_rsp, grp_rsp;

  logic              reserved;
  logic              tbl_hit;
  logic              bad_set;
  logic [POS_W-1:0]  n_groups;
  logic [KIND_W-1:0] res_kind;
  logic [ID_W-1:0]   res_id;

  function automatic logic takes(logic [KIND_W-1:0] cur, logic [KIND_W-1:0] kind);
    return (cur == KIND_NONE) || (kind < cur);
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign reserved = (id_r == '0) || (id_r < min_id_r);
  assign tbl_hit  = usr_rsp.hit | grp_rsp.hit;

  assign n_groups = (pos_r >= POS_GROUPS) ? pos_r - POS_GROUPS : '0;
  assign bad_set  = (pos_r < POS_GROUPS) || (32'(n_groups) > 32'(MAX_GROUPS)) ||
                    (pkind_r == KIND_MALFORMED);
  assign res_kind = bad_set ? KIND_MALFORMED : pkind_r;
  assign res_id   = bad_set ? ID_W'(n_groups) : pid_r;

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    id_nxt          = id_r;
    last_nxt        = last_r;
    hit_kind_nxt    = hit_kind_r;
    pos_nxt         = pos_r;
    pkind_nxt       = pkind_r;
    pid_nxt         = pid_r;
    out_valid_nxt   = out_valid_r;
    out_allowed_nxt = out_allowed_r;
    out_kind_nxt    = out_kind_r;
    out_id_nxt      = out_id_r;
    usr_req         = '0;
    grp_req         = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          id_nxt    = in_id_value;
          last_nxt  = in_last;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (act_r)
          ACT_CLEAR: begin
            usr_req.clear = 1'b1;
            grp_req.clear = 1'b1;
            state_nxt     = ST_IDLE;
          end
          ACT_ADD_USER: begin
            usr_req.start  = 1'b1;
            usr_req.insert = 1'b1;
            hit_kind_nxt   = KIND_NONE;
            state_nxt      = ST_SCAN;
          end
          ACT_ADD_GROUP: begin
            grp_req.start  = 1'b1;
            grp_req.insert = 1'b1;
            hit_kind_nxt   = KIND_NONE;
            state_nxt      = ST_SCAN;
          end
          ACT_USER: begin
            pos_nxt = POS_EXPECT_PRIM;
            if (reserved) begin
              pkind_nxt = KIND_USER_RES;
              pid_nxt   = id_r;
              state_nxt = last_r ? ST_RESULT : ST_IDLE;
            end else begin
              pkind_nxt     = KIND_NONE;
              pid_nxt       = '0;
              usr_req.start = 1'b1;
              hit_kind_nxt  = KIND_FORBID_USER;
              state_nxt     = ST_SCAN;
            end
          end
          ACT_PRIMARY, ACT_SUPP: begin
            if ((act_r == ACT_PRIMARY && pos_r != POS_EXPECT_PRIM) ||
                (act_r == ACT_SUPP && pos_r < POS_GROUPS)) begin
              if (takes(pkind_r, KIND_MALFORMED)) begin
                pkind_nxt = KIND_MALFORMED;
                pid_nxt   = '0;
              end
              if (act_r == ACT_SUPP) begin
                pos_nxt = POS_GROUPS + POS_W'(1);
              end else if (pos_r < POS_GROUPS) begin
                pos_nxt = POS_GROUPS;
              end
              state_nxt = last_r ? ST_RESULT : ST_IDLE;
            end else begin
              if (act_r == ACT_PRIMARY) begin
                pos_nxt = POS_GROUPS;
              end else if (pos_r != POS_SAT) begin
                pos_nxt = pos_r + POS_W'(1);
              end
              if (reserved) begin
                if (takes(pkind_r,
                          (act_r == ACT_PRIMARY) ? KIND_PRIM_RES : KIND_SUPP_RES)) begin
                  pkind_nxt = (act_r == ACT_PRIMARY) ? KIND_PRIM_RES : KIND_SUPP_RES;
                  pid_nxt   = id_r;
                end
                state_nxt = last_r ? ST_RESULT : ST_IDLE;
              end else begin
                grp_req.start = 1'b1;
                hit_kind_nxt  = KIND_FORBID_GROUP;
                state_nxt     = ST_SCAN;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (usr_rsp.done || grp_rsp.done) begin
          if (tbl_hit && (hit_kind_r != KIND_NONE) && takes(pkind_r, hit_kind_r)) begin
            pkind_nxt = hit_kind_r;
            pid_nxt   = id_r;
          end
          state_nxt = ((hit_kind_r != KIND_NONE) && last_r) ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = (res_kind == KIND_NONE);
          out_kind_nxt    = res_kind;
          out_id_nxt      = (res_kind == KIND_NONE) ? '0 : res_id;
          pos_nxt         = POS_EXPECT_USER;
          pkind_nxt       = KIND_NONE;
          pid_nxt         = '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_EXPECT_USER;
      pkind_r     <= KIND_NONE;
      pid_r       <= '0;
      min_id_r    <= MIN_ID_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pkind_r     <= pkind_nxt;
      pid_r       <= pid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_id_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    id_r          <= id_nxt;
    last_r        <= last_nxt;
    hit_kind_r    <= hit_kind_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_kind_r    <= out_kind_nxt;
    out_id_r      <= out_id_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_allowed        = out_allowed_r;
  assign out_violation_kind = out_kind_r;
  assign out_offending_id   = out_id_r;

  cdl_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_usr_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (usr_req),
    .key   (id_r),
    .rsp   (usr_rsp)
  );

  cdl_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_grp_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (grp_req),
    .key   (id_r),
    .rsp   (grp_rsp)
  );

  a_allow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_allowed |-> out_violation_kind == KIND_NONE && out_offending_id == '0)
    else $error("allowed word carries a violation");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (usr_rsp.done || grp_rsp.done) |-> state_r == ST_SCAN)
    else $error("table response outside scan");

  a_one_table: assert property (@(posedge clk) disable iff (!rst_n)
    !(usr_rsp.done && grp_rsp.done))
    else $error("both tables responded");

  a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
    pkind_r == KIND_NONE |-> pid_r == '0)
    else $error("pending id without violation");

endmodule

// File: src/cdl_ram.sv
// ----------------------------------------------------------------------------
// cdl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/cdl_table.sv
// ----------------------------------------------------------------------------
// cdl_table
// Bounded id set: fill count plus a RAM of eight-id rows, scanned one row
// per cycle for lookup and duplicate-checked insert.
// ----------------------------------------------------------------------------
module cdl_table #(
  parameter int DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdl_pkg::cdl_tbl_req_t       req,
  input  logic [cdl_pkg::ID_W-1:0]    key,
  output cdl_pkg::cdl_tbl_rsp_t       rsp
);
  import cdl_pkg::*;

  localparam int ROWS = (DEPTH + LANES - 1) / LANES;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = AW + LANE_BITS + 1;

  localparam logic [1:0] TS_IDLE = 2'd0;
  localparam logic [1:0] TS_SCAN = 2'd1;
  localparam logic [1:0] TS_FIN  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   row_r, row_nxt;
  logic [AW-1:0]   last_row_r, last_row_nxt;
  logic            hit_r, hit_nxt;
  logic            insert_r, insert_nxt;
  logic [ID_W-1:0] key_r, key_nxt;
  cdl_row_t        row_data_r, row_data_nxt;

  cdl_row_t        rd_data;
  cdl_row_t        wr_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [IW-1:0]   cnt_w;
  logic [IW-1:0]   cnt_m1;
  logic [IW-1:0]   row_base;
  logic [LANE_BITS-1:0] wr_lane;
  logic [LANES-1:0] lane_hit;

  assign cnt_w    = IW'(count_r);
  assign cnt_m1   = cnt_w - IW'(1);
  assign row_base = IW'(row_r) << LANE_BITS;
  assign wr_lane  = cnt_w[LANE_BITS-1:0];
  assign wr_addr  = cnt_w[AW+LANE_BITS-1:LANE_BITS];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_hit[i] = (rd_data[i] == key_r) && ((row_base + IW'(i)) < cnt_w);
    end
  end

  always_comb begin
    wr_data          = row_data_r;
    wr_data[wr_lane] = key_r;
  end

  assign rd_addr = (state_r == TS_SCAN) ? row_r + AW'(1) : '0;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    row_nxt      = row_r;
    last_row_nxt = last_row_r;
    hit_nxt      = hit_r;
    insert_nxt   = insert_r;
    key_nxt      = key_r;
    row_data_nxt = row_data_r;
    wr_en        = 1'b0;
    rsp          = '0;
    case (state_r)
      TS_IDLE: begin
        if (req.clear) begin
          count_nxt = '0;
        end
        if (req.start) begin
          key_nxt      = key;
          insert_nxt   = req.insert;
          hit_nxt      = 1'b0;
          row_nxt      = '0;
          last_row_nxt = cnt_m1[AW+LANE_BITS-1:LANE_BITS];
          state_nxt    = (count_r == '0) ? TS_FIN : TS_SCAN;
        end
      end
      TS_SCAN: begin
        row_data_nxt = rd_data;
        if ((|lane_hit) || (row_r == last_row_r)) begin
          hit_nxt   = |lane_hit;
          state_nxt = TS_FIN;
        end else begin
          row_nxt = row_r + AW'(1);
        end
      end
      TS_FIN: begin
        rsp.done = 1'b1;
        rsp.hit  = hit_r;
        if (insert_r && !hit_r && (cnt_w < IW'(DEPTH))) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = TS_IDLE;
      end
      default: begin
        state_nxt = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    last_row_r <= last_row_nxt;
    hit_r      <= hit_nxt;
    insert_r   <= insert_nxt;
    key_r      <= key_nxt;
    row_data_r <= row_data_nxt;
  end

  cdl_ram #(
    .WIDTH ($bits(cdl_row_t)),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
